// ===== rtl/core/bfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfc_pkg: shared constants, types and helpers for the box frustum cull block
// Plane register layout, arithmetic widths and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none
package bfc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int AXES        = 3;
  localparam int COORD_W     = 28;
  localparam int NORM_W      = 12;
  localparam int OFFSET_W    = 28;
  localparam int NORM_FRAC   = 10;
  localparam int PLANE_W     = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Bit positions inside a plane register.
  localparam int NX_LSB = 0;
  localparam int NY_LSB = 12;
  localparam int NZ_LSB = 24;
  localparam int W_LSB  = 36;

  // One product of a normal component and a coordinate.
  localparam int PROD_W = NORM_W + COORD_W;
  // Three products plus the scaled offset, with headroom.
  localparam int DIST_W = PROD_W + 2;

  // Front-to-back queue entry: which planes this vertex was in front of.
  typedef struct packed {
    logic [PLANE_COUNT-1:0] front;
    logic                   last;
  } entry_t;

  typedef logic [PLANE_W-1:0] plane_t;

  function automatic logic signed [NORM_W-1:0] plane_norm(input plane_t pl, input int axis);
    logic signed [NORM_W-1:0] n;
    case (axis)
      0:       n = $signed(pl[NX_LSB +: NORM_W]);
      1:       n = $signed(pl[NY_LSB +: NORM_W]);
      default: n = $signed(pl[NZ_LSB +: NORM_W]);
    endcase
    return n;
  endfunction

  function automatic logic signed [OFFSET_W-1:0] plane_offset(input plane_t pl);
    return $signed(pl[W_LSB +: OFFSET_W]);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/box_frustum_cull.sv =====
// ----------------------------------------------------------------------------
// box_frustum_cull: bounding box test against six view planes
// Classifies each box vertex against the configured planes and reports per box
// whether it can be culled.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index (3b), cfg_data (64b plane)
//  in      | in_valid/in_ready    | in_vert_x/y/z (28b signed), in_last_vertex
//  out     | out_valid/out_ready  | out_box_visible
//
// One vertex is accepted per cycle; the rate is set by the two-stage
// classifier pipeline, which advances every cycle while the queue has room.
// out_valid for a box rises once its final vertex has passed both classifier
// stages and the queue and been popped into the result register. Reset clears
// the planes to zero, the box flags and all valid state; no clearing pass is
// needed. A stalled output holds only final vertices back: the queue and
// pipeline keep absorbing vertices until they fill.
// ----------------------------------------------------------------------------
`default_nettype none
module box_frustum_cull (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bfc_pkg::PLANE_W-1:0]          cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [bfc_pkg::COORD_W-1:0]   in_vert_x,
  input  wire logic signed [bfc_pkg::COORD_W-1:0]   in_vert_y,
  input  wire logic signed [bfc_pkg::COORD_W-1:0]   in_vert_z,
  input  wire logic                                 in_last_vertex,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_box_visible
);

  logic            push_valid;
  logic            push_ready;
  bfc_pkg::entry_t push_data;
  logic            pop_valid;
  logic            pop_ready;
  bfc_pkg::entry_t pop_data;

  assign cfg_ready = 1'b1;

  bfc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vert_x      (in_vert_x),
    .in_vert_y      (in_vert_y),
    .in_vert_z      (in_vert_z),
    .in_last_vertex (in_last_vertex),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  bfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bfc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_box_visible (out_box_visible)
  );

endmodule
`default_nettype wire

// ===== rtl/core/bfc_front.sv =====
// ----------------------------------------------------------------------------
// bfc_front: plane registers and two-stage vertex classifier
// Stage one forms all normal-by-coordinate products, stage two adds them with
// the scaled offset and marks the planes the vertex lies strictly in front of.
// ----------------------------------------------------------------------------
`default_nettype none
module bfc_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  input  wire logic [bfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bfc_pkg::PLANE_W-1:0]          cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [bfc_pkg::COORD_W-1:0]   in_vert_x,
  input  wire logic signed [bfc_pkg::COORD_W-1:0]   in_vert_y,
  input  wire logic signed [bfc_pkg::COORD_W-1:0]   in_vert_z,
  input  wire logic                                 in_last_vertex,
  output logic                                      push_valid,
  input  wire logic                                 push_ready,
  output bfc_pkg::entry_t                           push_data
);

  bfc_pkg::plane_t plane_r [bfc_pkg::PLANE_COUNT];

  logic                             s1_v_r;
  logic                             s1_last_r;
  logic signed [bfc_pkg::PROD_W-1:0] s1_prod_r   [bfc_pkg::PLANE_COUNT][bfc_pkg::AXES];
  logic signed [bfc_pkg::PROD_W-1:0] s1_prod_nxt [bfc_pkg::PLANE_COUNT][bfc_pkg::AXES];

  logic                               s2_v_r;
  logic                               s2_last_r;
  logic [bfc_pkg::PLANE_COUNT-1:0]    s2_front_r;
  logic [bfc_pkg::PLANE_COUNT-1:0]    s2_front_nxt;

  logic s1_adv;
  logic s2_adv;

  assign s2_adv   = !s2_v_r || push_ready;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  assign push_valid      = s2_v_r;
  assign push_data.front = s2_front_r;
  assign push_data.last  = s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < bfc_pkg::PLANE_COUNT; p++) begin
        plane_r[p] <= '0;
      end
    end else if (cfg_valid &&
                 ({1'b0, cfg_index} < (bfc_pkg::CFG_IDX_W + 1)'(bfc_pkg::PLANE_COUNT))) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int p = 0; p < bfc_pkg::PLANE_COUNT; p++) begin
      for (int a = 0; a < bfc_pkg::AXES; a++) begin
        logic signed [bfc_pkg::NORM_W-1:0]  n;
        logic signed [bfc_pkg::COORD_W-1:0] c;
        logic signed [bfc_pkg::PROD_W-1:0]  n_ext;
        logic signed [bfc_pkg::PROD_W-1:0]  c_ext;
        n = bfc_pkg::plane_norm(plane_r[p], a);
        case (a)
          0:       c = in_vert_x;
          1:       c = in_vert_y;
          default: c = in_vert_z;
        endcase
        n_ext = {{(bfc_pkg::PROD_W - bfc_pkg::NORM_W){n[bfc_pkg::NORM_W-1]}}, n};
        c_ext = {{(bfc_pkg::PROD_W - bfc_pkg::COORD_W){c[bfc_pkg::COORD_W-1]}}, c};
        s1_prod_nxt[p][a] = n_ext * c_ext;
      end
    end
  end

  // The offset is Q20.8 while the products sit at scale 2^18, hence the shift.
  always_comb begin
    for (int p = 0; p < bfc_pkg::PLANE_COUNT; p++) begin
      logic signed [bfc_pkg::OFFSET_W-1:0] w;
      logic signed [bfc_pkg::DIST_W-1:0]   d;
      w = bfc_pkg::plane_offset(plane_r[p]);
      d = {{(bfc_pkg::DIST_W - bfc_pkg::OFFSET_W - bfc_pkg::NORM_FRAC){w[bfc_pkg::OFFSET_W-1]}},
           w, {bfc_pkg::NORM_FRAC{1'b0}}};
      for (int a = 0; a < bfc_pkg::AXES; a++) begin
        d = d + {{(bfc_pkg::DIST_W - bfc_pkg::PROD_W){s1_prod_r[p][a][bfc_pkg::PROD_W-1]}},
                 s1_prod_r[p][a]};
      end
      s2_front_nxt[p] = !d[bfc_pkg::DIST_W-1] && (|d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_last_r <= in_last_vertex;
      s1_prod_r <= s1_prod_nxt;
    end
    if (s2_adv && s1_v_r) begin
      s2_last_r  <= s1_last_r;
      s2_front_r <= s2_front_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bfc_queue.sv =====
// ----------------------------------------------------------------------------
// bfc_queue: short FIFO between the classifier and the box accumulator
// Holds per-vertex plane flags so either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none
module bfc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire bfc_pkg::entry_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output bfc_pkg::entry_t      pop_data
);

  bfc_pkg::entry_t               slot_r [bfc_pkg::QUEUE_DEPTH];
  logic [bfc_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [bfc_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [bfc_pkg::QCNT_W-1:0]    count_r;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = (count_r != bfc_pkg::QCNT_W'(bfc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bfc_back.sv =====
// ----------------------------------------------------------------------------
// bfc_back: per-box accumulator and result register
// Collects the front-of-plane flags over a box and issues the verdict on the
// flagged final vertex.
// ----------------------------------------------------------------------------
`default_nettype none
module bfc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire bfc_pkg::entry_t pop_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_box_visible
);

  logic [bfc_pkg::PLANE_COUNT-1:0] seen_r;
  logic [bfc_pkg::PLANE_COUNT-1:0] seen_nxt;
  logic                            out_valid_r;
  logic                            out_vis_r;
  logic                            do_pop;

  // Only a final vertex needs the result register to be free.
  assign pop_ready = !pop_data.last || !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;
  assign seen_nxt  = seen_r | pop_data.front;

  assign out_valid       = out_valid_r;
  assign out_box_visible = out_vis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_pop && pop_data.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_pop) begin
        if (pop_data.last) begin
          seen_r <= '0;
        end else begin
          seen_r <= seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_data.last) begin
      out_vis_r <= &seen_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bfc_checker.sv =====
// ----------------------------------------------------------------------------
// bfc_checker: port-level checks for the box frustum cull block
// Tracks boxes whose final vertex was taken but whose result is still owed.
// ----------------------------------------------------------------------------
`default_nettype none
module bfc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_last_vertex,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_box_visible
);

  // Two pipeline stages, the queue and the result register bound the backlog.
  localparam int MAX_OWED = bfc_pkg::QUEUE_DEPTH + 3;

  logic [3:0] owed_r;
  logic       box_in;
  logic       box_out;

  assign box_in  = in_valid && in_ready && in_last_vertex;
  assign box_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0;
    end else begin
      owed_r <= owed_r + {3'b000, box_in} - {3'b000, box_out};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_box_visible))
    else $error("result changed or dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> owed_r != 4'd0)
    else $error("result shown with no box outstanding");

  a_backlog_bound: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r <= 4'(MAX_OWED))
    else $error("more boxes outstanding than the block can hold");

endmodule

bind box_frustum_cull bfc_checker u_bfc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_vertex  (in_last_vertex),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_box_visible (out_box_visible)
);
`default_nettype wire

// ===== tb/sv/box_frustum_cull_tb.sv =====
// ----------------------------------------------------------------------------
// box_frustum_cull_tb: self-checking testbench for the box frustum cull block
// Streams box vertices against several plane settings: a directed table, then
// random boxes. Every box is checked against a table verdict or a predictor that
// classifies each vertex against the six planes. Both sides stall at random.
// ----------------------------------------------------------------------------
module box_frustum_cull_tb;

  localparam int HALF_PERIOD  = 6;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 85;
  localparam int QUIET_PHASES = 2;
  localparam int COORD_MAX    = 2 ** (bfc_pkg::COORD_W - 1) - 1;
  localparam int COORD_MIN    = -(2 ** (bfc_pkg::COORD_W - 1));
  localparam int CUBE_HALF    = 4096;

  typedef enum logic [bfc_pkg::CFG_IDX_W-1:0] {
    PL_NEAR, PL_FAR, PL_LEFT, PL_RIGHT, PL_TOP, PL_BOTTOM, PL_SPARE6, PL_SPARE7
  } plane_sel_t;

  typedef enum logic {ROW_CFG, ROW_VERT} row_kind_t;
  typedef enum int {MODE_FRUSTUM, MODE_RANDOM, MODE_EXTREME} plane_mode_t;

  typedef logic signed [bfc_pkg::COORD_W-1:0]  coord_t;
  typedef logic signed [bfc_pkg::NORM_W-1:0]   norm_t;
  typedef logic signed [bfc_pkg::OFFSET_W-1:0] offset_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } vertex_t;

  typedef struct {
    row_kind_t       kind;
    plane_sel_t      sel;
    bfc_pkg::plane_t data;
    vertex_t         vtx;
    bit              typed;
    bit              vis;
  } row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bfc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bfc_pkg::PLANE_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  coord_t                         in_vert_x = '0;
  coord_t                         in_vert_y = '0;
  coord_t                         in_vert_z = '0;
  logic                           in_last_vertex = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_box_visible;

  // Predictor state: plane registers and the per-plane front flags of the open box.
  bfc_pkg::plane_t                  plane_model [bfc_pkg::PLANE_COUNT];
  logic [bfc_pkg::PLANE_COUNT-1:0]  front_model = '0;
  bit                               visible_q [$];

  bit cur_typed = 1'b0;
  bit cur_vis   = 1'b0;
  int idle_pct  = 20;
  int idle_cycles = 0;
  int errors = 0;
  int vertices_sent = 0;
  int boxes_checked = 0;
  int boxes_culled = 0;
  int cfg_writes = 0;

  box_frustum_cull DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_vert_x       (in_vert_x),
    .in_vert_y       (in_vert_y),
    .in_vert_z       (in_vert_z),
    .in_last_vertex  (in_last_vertex),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_box_visible (out_box_visible)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  initial begin
    for (int p = 0; p < bfc_pkg::PLANE_COUNT; p++) plane_model[p] = '0;
  end

  // Returns one bit per plane: set where the vertex lies strictly in front.
  function automatic logic [bfc_pkg::PLANE_COUNT-1:0] planes_in_front(vertex_t v);
    logic [bfc_pkg::PLANE_COUNT-1:0] mask;
    norm_t   nx, ny, nz;
    offset_t w;
    longint  plane_dist;
    mask = '0;
    for (int p = 0; p < bfc_pkg::PLANE_COUNT; p++) begin
      nx = plane_model[p][bfc_pkg::NX_LSB +: bfc_pkg::NORM_W];
      ny = plane_model[p][bfc_pkg::NY_LSB +: bfc_pkg::NORM_W];
      nz = plane_model[p][bfc_pkg::NZ_LSB +: bfc_pkg::NORM_W];
      w  = plane_model[p][bfc_pkg::W_LSB +: bfc_pkg::OFFSET_W];
      plane_dist = longint'(nx) * longint'($signed(v.x))
                 + longint'(ny) * longint'($signed(v.y))
                 + longint'(nz) * longint'($signed(v.z))
                 + longint'(w) * (longint'(1) << bfc_pkg::NORM_FRAC);
      mask[p] = (plane_dist > 0);
    end
    return mask;
  endfunction

  function automatic bfc_pkg::plane_t pack_plane(norm_t nx, norm_t ny, norm_t nz, offset_t w);
    return {w, nz, ny, nx};
  endfunction

  function automatic row_t vert_row(int x, int y, int z, bit last, bit typed = 0, bit vis = 0);
    row_t r;
    r.kind  = ROW_VERT;
    r.sel   = PL_NEAR;
    r.data  = '0;
    r.vtx   = {coord_t'(x), coord_t'(y), coord_t'(z), last};
    r.typed = typed;
    r.vis   = vis;
    return r;
  endfunction

  function automatic row_t cfg_row(plane_sel_t sel, bfc_pkg::plane_t data);
    row_t r;
    r.kind  = ROW_CFG;
    r.sel   = sel;
    r.data  = data;
    r.vtx   = '0;
    r.typed = 0;
    r.vis   = 0;
    return r;
  endfunction

  function automatic coord_t wild_coord();
    case ($urandom_range(0, 7))
      0:       return coord_t'(COORD_MIN);
      1:       return coord_t'(COORD_MAX);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic norm_t extreme_norm();
    case ($urandom_range(0, 2))
      0:       return 12'sh800;
      1:       return 12'sh7FF;
      default: return '0;
    endcase
  endfunction

  function automatic bfc_pkg::plane_t random_plane(plane_mode_t mode, int p);
    norm_t   n [3];
    offset_t w;
    int      axis;
    int      mag;
    case (mode)
      MODE_RANDOM: return {$urandom, $urandom};
      MODE_EXTREME: begin
        for (int a = 0; a < 3; a++) n[a] = extreme_norm();
        case ($urandom_range(0, 2))
          0:       w = 28'sh8000000;
          1:       w = 28'sh7FFFFFF;
          default: w = '0;
        endcase
        return pack_plane(n[0], n[1], n[2], w);
      end
      default: begin
        if ($urandom_range(0, 9) == 0) return '0;
        // Axis-dominant normal pointing inward, so the six planes close a region.
        axis = (p < 2) ? 2 : (p < 4) ? 0 : 1;
        for (int a = 0; a < 3; a++) n[a] = norm_t'(int'($urandom_range(0, 512)) - 256);
        mag = $urandom_range(512, 2047);
        n[axis] = (p == PL_FAR || p == PL_RIGHT || p == PL_TOP) ? norm_t'(-mag) : norm_t'(mag);
        if ($urandom_range(0, 9) == 0) w = offset_t'(-int'($urandom_range(0, 4096)));
        else w = offset_t'($urandom_range(0, 1 << 15));
        return pack_plane(n[0], n[1], n[2], w);
      end
    endcase
  endfunction

  // Scoreboard and predictor, sampled at the rising edge.
  always @(posedge clk) begin
    bit                              moved;
    bit                              exp_vis;
    vertex_t                         v;
    logic [bfc_pkg::PLANE_COUNT-1:0] seen;
    if (rst_n) begin
      moved = 0;
      if (cfg_valid && cfg_ready) begin
        moved = 1;
        if (cfg_index < bfc_pkg::PLANE_COUNT) plane_model[cfg_index] = cfg_data;
      end
      if (out_valid && out_ready) begin
        moved = 1;
        if (visible_q.size() == 0) begin
          $error("out_box_visible: no box pending, actual %0d", out_box_visible);
          errors++;
        end else begin
          exp_vis = visible_q.pop_front();
          boxes_checked++;
          if (!exp_vis) boxes_culled++;
          if (out_box_visible !== exp_vis) begin
            $error("out_box_visible: expected %0d, actual %0d", exp_vis, out_box_visible);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1;
        vertices_sent++;
        v = {in_vert_x, in_vert_y, in_vert_z, in_last_vertex};
        seen = front_model | planes_in_front(v);
        if (in_last_vertex) begin
          visible_q.push_back(cur_typed ? cur_vis : (&seen));
          seen = '0;
        end
        front_model = seen;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side back-pressure in random bursts.
  initial begin
    int run;
    forever begin
      if (idle_pct != 0 && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        run = $urandom_range(1, 15);
      end else begin
        out_ready = 1'b1;
        run = $urandom_range(1, 20);
      end
      repeat (run) @(negedge clk);
    end
  end

  task automatic drive_vertex(input vertex_t v, input bit typed, input bit vis);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_vert_x      = v.x;
    in_vert_y      = v.y;
    in_vert_z      = v.z;
    in_last_vertex = v.last;
    cur_typed      = typed;
    cur_vis        = vis;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops the vertex stream and waits until every pending box has been reported
  // and the pipeline has emptied of trailing unflagged vertices.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (visible_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_plane(input plane_sel_t sel, input bfc_pkg::plane_t data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  task automatic send_box(output int count);
    int      kind;
    int      cx, cy, cz, hx, hy, hz;
    vertex_t v;
    kind  = $urandom_range(0, 99);
    count = (kind < 75) ? 8 : $urandom_range(1, 12);
    cx = int'($urandom_range(0, 65536)) - 32768;
    cy = int'($urandom_range(0, 65536)) - 32768;
    cz = int'($urandom_range(0, 65536)) - 32768;
    hx = $urandom_range(0, 4096);
    hy = $urandom_range(0, 4096);
    hz = $urandom_range(0, 4096);
    for (int i = 0; i < count; i++) begin
      if (kind < 90) begin
        v.x = coord_t'(cx + (i[0] ? hx : -hx));
        v.y = coord_t'(cy + (i[1] ? hy : -hy));
        v.z = coord_t'(cz + (i[2] ? hz : -hz));
      end else begin
        v.x = wild_coord();
        v.y = wild_coord();
        v.z = wild_coord();
      end
      v.last = (i == count - 1);
      drive_vertex(v, 0, 0);
    end
  endtask

  initial begin
    row_t        rows [$];
    plane_mode_t mode;
    int          phase_items;
    int          n;
    int          total_random;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Planes are all zero after reset, so every box is culled.
    rows.push_back(vert_row(COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 0));
    rows.push_back(vert_row(COORD_MIN, COORD_MIN, COORD_MIN, 0));
    rows.push_back(vert_row(0, 0, 0, 1, 1, 0));
    // Zero normals with the largest offset put every vertex in front.
    for (int p = 0; p < bfc_pkg::PLANE_COUNT; p++)
      rows.push_back(cfg_row(plane_sel_t'(p), pack_plane(0, 0, 0, 28'sh7FFFFFF)));
    rows.push_back(vert_row(COORD_MIN, COORD_MAX, COORD_MIN, 1, 1, 1));
    // Writes above the last plane index change nothing.
    rows.push_back(cfg_row(PL_SPARE6, '0));
    rows.push_back(cfg_row(PL_SPARE7, '0));
    rows.push_back(vert_row(0, 0, 0, 1, 1, 1));
    // The most negative offset puts every vertex behind the left plane.
    rows.push_back(cfg_row(PL_LEFT, pack_plane(0, 0, 0, 28'sh8000000)));
    rows.push_back(vert_row(COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 0));
    // Axis-aligned cube of half size CUBE_HALF around the origin.
    rows.push_back(cfg_row(PL_NEAR,   pack_plane(0, 0, 1024, CUBE_HALF)));
    rows.push_back(cfg_row(PL_FAR,    pack_plane(0, 0, -1024, CUBE_HALF)));
    rows.push_back(cfg_row(PL_LEFT,   pack_plane(1024, 0, 0, CUBE_HALF)));
    rows.push_back(cfg_row(PL_RIGHT,  pack_plane(-1024, 0, 0, CUBE_HALF)));
    rows.push_back(cfg_row(PL_TOP,    pack_plane(0, -1024, 0, CUBE_HALF)));
    rows.push_back(cfg_row(PL_BOTTOM, pack_plane(0, 1024, 0, CUBE_HALF)));
    for (int i = 0; i < 8; i++)
      rows.push_back(vert_row(i[0] ? 100 : -100, i[1] ? 100 : -100, i[2] ? 100 : -100, i == 7));
    rows.push_back(vert_row(10000, 0, 0, 0));
    rows.push_back(vert_row(10000, 50, 50, 1));
    // A three-vertex box straddling the cube.
    rows.push_back(vert_row(-10000, 0, 0, 0));
    rows.push_back(vert_row(10000, 0, 0, 0));
    rows.push_back(vert_row(0, 0, 0, 1));
    // A lone vertex exactly on the left plane is not in front of it.
    rows.push_back(vert_row(-CUBE_HALF, 0, 0, 1));
    rows.push_back(cfg_row(PL_NEAR, pack_plane(12'sh800, 12'sh7FF, 12'sh800, 28'sh7FFFFFF)));
    rows.push_back(cfg_row(PL_FAR,  pack_plane(12'sh7FF, 12'sh800, 12'sh7FF, 28'sh8000000)));
    rows.push_back(vert_row(COORD_MAX, COORD_MIN, COORD_MAX, 1));
    rows.push_back(vert_row(COORD_MIN, COORD_MAX, COORD_MIN, 1));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_plane(rows[i].sel, rows[i].data);
      end else begin
        drive_vertex(rows[i].vtx, rows[i].typed, rows[i].vis);
      end
    end

    total_random = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph % 4)
        1:       mode = MODE_RANDOM;
        3:       mode = MODE_EXTREME;
        default: mode = MODE_FRUSTUM;
      endcase
      for (int p = 0; p < bfc_pkg::PLANE_COUNT; p++)
        write_plane(plane_sel_t'(p), random_plane(mode, p));
      if ($urandom_range(0, 2) == 0)
        write_plane($urandom_range(0, 1) ? PL_SPARE6 : PL_SPARE7, {$urandom, $urandom});
      if (ph >= PHASES - QUIET_PHASES) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          2:       idle_pct = 25;
          default: idle_pct = 50;
        endcase
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_box(n);
        phase_items += n;
        if (idle_pct != 0 && $urandom_range(0, 39) == 0) drain();
      end
      total_random += phase_items;
    end

    drain();
    $display("Sent %0d vertices (%0d random) with %0d register writes.",
             vertices_sent, total_random, cfg_writes);
    $display("Checked %0d boxes, %0d of them culled.", boxes_checked, boxes_culled);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bfc_pkg.sv
rtl/core/bfc_front.sv
rtl/core/bfc_queue.sv
rtl/core/bfc_back.sv
rtl/core/box_frustum_cull.sv
rtl/core/bfc_checker.sv
tb/sv/box_frustum_cull_tb.sv
